// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LPRR_ASSERT_IMP(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LPRR_ASSERT_NXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lprr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lprr_pkg;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [2:0] ST_STORED    = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_DELIVERED = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_BADLEN    = 3'd4;

  localparam int PADDR_W      = 3;
  localparam int PREFIX_BYTES = 4;

  typedef struct packed {
    logic       is_read;
    logic [7:0] data;
  } item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_PFX,
    S_DATA
  } back_state_t;

endpackage

`default_nettype wire

// ----- rtl/lprr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lprr_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          op,
  input  wire logic [7:0]    byte_in,
  output logic               q_valid,
  output lprr_pkg::item_t    q_item,
  input  wire logic          q_pop
);
  import lprr_pkg::*;

  item_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr].is_read <= (op == OP_READ);
      entries[wr_ptr].data    <= byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop && q_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !(q_pop && q_valid)) begin
        count <= count + 2'd1;
      end else if (!push && q_pop && q_valid) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lprr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lprr_back #(
  parameter int RING_BYTES = 256,
  parameter int MAX_RECORD = 140
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          prefix_mode,
  input  wire logic          q_valid,
  input  wire lprr_pkg::item_t q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [31:0]        data_word,
  output logic [2:0]         byte_count,
  output logic [7:0]         record_length,
  output logic [2:0]         status,
  output logic               last
);
  import lprr_pkg::*;

  localparam int PTR_W  = $clog2(RING_BYTES);
  localparam int FILL_W = $clog2(RING_BYTES + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_BYTES - 1);

  logic [7:0] ring_mem [RING_BYTES];
  logic [7:0] mem_q;

  back_state_t       state, state_next;
  item_t             cur, cur_next;
  logic [PTR_W-1:0]  rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0]  wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]  wk, wk_next, wk_adv, wr_adv;
  logic [FILL_W-1:0] fill, fill_next;
  logic [1:0]        pidx, pidx_next;
  logic [23:0]       len_lo, len_lo_next;
  logic [7:0]        rem, rem_next;
  logic [7:0]        rlen, rlen_next;
  logic [8:0]        take, take_next;
  logic [31:0]       acc, acc_next;
  logic [1:0]        bidx, bidx_next;

  logic        mem_we;
  logic        can_emit;
  logic        emit;
  logic [31:0] e_word;
  logic [2:0]  e_cnt;
  logic [7:0]  e_len;
  logic [2:0]  e_st;
  logic        e_last;

  logic [31:0] fill32;
  logic [31:0] avail;
  logic [31:0] len32;
  logic [7:0]  n_fixed;
  logic [7:0]  n_pfx;
  logic [2:0]  gs;
  logic [31:0] merged;

  assign wk_adv   = (wk == PTR_LAST) ? '0 : wk + 1'b1;
  assign wr_adv   = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
  assign can_emit = !out_valid || out_ready;
  assign fill32   = 32'(fill);
  assign avail    = fill32 - 32'(PREFIX_BYTES);
  assign len32    = {mem_q, len_lo};
  assign n_fixed  = (fill32 > 32'(MAX_RECORD)) ? 8'(MAX_RECORD) : fill[7:0];
  assign n_pfx    = (len32 < avail) ? len32[7:0] : avail[7:0];
  assign gs       = (rem >= 8'd4) ? 3'd4 : rem[2:0];

  always_comb begin
    merged = acc;
    case (bidx)
      2'd0:    merged[7:0]   = mem_q;
      2'd1:    merged[15:8]  = mem_q;
      2'd2:    merged[23:16] = mem_q;
      default: merged[31:24] = mem_q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[wr_ptr] <= cur.data;
    end
    mem_q <= ring_mem[wk_next];
  end

  always_comb begin
    state_next  = state;
    cur_next    = cur;
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    wk_next     = wk;
    fill_next   = fill;
    pidx_next   = pidx;
    len_lo_next = len_lo;
    rem_next    = rem;
    rlen_next   = rlen;
    take_next   = take;
    acc_next    = acc;
    bidx_next   = bidx;
    q_pop       = 1'b0;
    mem_we      = 1'b0;
    emit        = 1'b0;
    e_word      = '0;
    e_cnt       = '0;
    e_len       = '0;
    e_st        = ST_STORED;
    e_last      = 1'b1;

    case (state)
      S_IDLE: begin
        wk_next = rd_ptr;
        if (q_valid) begin
          q_pop      = 1'b1;
          cur_next   = q_item;
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        if (can_emit) begin
          if (!cur.is_read) begin
            emit       = 1'b1;
            state_next = S_IDLE;
            if (fill32 == 32'(RING_BYTES)) begin
              e_st = ST_FULL;
            end else begin
              mem_we      = 1'b1;
              wr_ptr_next = wr_adv;
              fill_next   = fill + 1'b1;
            end
          end else if (prefix_mode) begin
            if (fill32 <= 32'(PREFIX_BYTES)) begin
              emit       = 1'b1;
              e_st       = ST_EMPTY;
              state_next = S_IDLE;
            end else begin
              pidx_next  = 2'd0;
              state_next = S_PFX;
            end
          end else if (fill32 == 32'd0) begin
            emit       = 1'b1;
            e_st       = ST_EMPTY;
            state_next = S_IDLE;
          end else begin
            rem_next   = n_fixed;
            rlen_next  = n_fixed;
            take_next  = 9'(n_fixed);
            acc_next   = '0;
            bidx_next  = 2'd0;
            state_next = S_DATA;
          end
        end
      end

      S_PFX: begin
        if (pidx != 2'd3) begin
          case (pidx)
            2'd0:    len_lo_next[7:0]   = mem_q;
            2'd1:    len_lo_next[15:8]  = mem_q;
            default: len_lo_next[23:16] = mem_q;
          endcase
          pidx_next = pidx + 2'd1;
          wk_next   = wk_adv;
        end else if (can_emit) begin
          if (len32 > 32'(MAX_RECORD)) begin
            emit       = 1'b1;
            e_st       = ST_BADLEN;
            state_next = S_IDLE;
          end else if (n_pfx == 8'd0) begin
            emit        = 1'b1;
            e_st        = ST_DELIVERED;
            rd_ptr_next = wk_adv;
            wk_next     = wk_adv;
            fill_next   = FILL_W'(fill32 - 32'(PREFIX_BYTES));
            state_next  = S_IDLE;
          end else begin
            rem_next   = n_pfx;
            rlen_next  = n_pfx;
            take_next  = 9'(n_pfx) + 9'(PREFIX_BYTES);
            acc_next   = '0;
            bidx_next  = 2'd0;
            wk_next    = wk_adv;
            state_next = S_DATA;
          end
        end
      end

      S_DATA: begin
        if ((3'(bidx) + 3'd1) == gs) begin
          if (can_emit) begin
            emit      = 1'b1;
            e_word    = merged;
            e_cnt     = gs;
            e_len     = rlen;
            e_st      = ST_DELIVERED;
            e_last    = (rem <= 8'd4);
            wk_next   = wk_adv;
            rem_next  = rem - 8'(gs);
            acc_next  = '0;
            bidx_next = 2'd0;
            if (rem <= 8'd4) begin
              rd_ptr_next = wk_adv;
              fill_next   = FILL_W'(fill32 - 32'(take));
              state_next  = S_IDLE;
            end
          end
        end else begin
          acc_next  = merged;
          bidx_next = bidx + 2'd1;
          wk_next   = wk_adv;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      wk        <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      wk     <= wk_next;
      fill   <= fill_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur    <= cur_next;
    pidx   <= pidx_next;
    len_lo <= len_lo_next;
    rem    <= rem_next;
    rlen   <= rlen_next;
    take   <= take_next;
    acc    <= acc_next;
    bidx   <= bidx_next;
    if (emit) begin
      data_word     <= e_word;
      byte_count    <= e_cnt;
      record_length <= e_len;
      status        <= e_st;
      last          <= e_last;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/length_prefixed_record_ring_core.sv -----
// Record ring with a byte push channel and a record read channel sharing one input.
// Each input item (op, byte_in) is taken on in_valid and in_ready into a two-entry
// queue. An op of 0 stores byte_in; an op of 1 reads one record. Every item yields
// one or more result items on the out channel (data_word, byte_count,
// record_length, status, last), and last marks the final one of each item.
// The APB register at address 0 selects length-prefix mode in bit 0.
// A push passes through the idle and execute states of the execution unit. A read
// also passes the prefix state in prefix mode and then the data state, where the
// ring memory gives one byte per cycle through its single read port while the
// output is not stalled. A read that delivers nothing or fails skips the data state.
// Reset empties the ring, clears the queue and out_valid, and sets
// fixed mode. Stored bytes keep no reset value.
// When the receiver holds out_ready low, the output register keeps its item and
// the execution unit stops; the input queue keeps taking items until it is full.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_record_ring_core #(
  parameter int RING_BYTES = 256,
  parameter int MAX_RECORD = 140
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        op,
  input  wire logic [7:0]                  byte_in,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [31:0]                      data_word,
  output logic [2:0]                       byte_count,
  output logic [7:0]                       record_length,
  output logic [2:0]                       status,
  output logic                             last,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lprr_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import lprr_pkg::*;

  logic  prefix_mode;
  logic  mode_sel;
  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  assign pready   = 1'b1;
  assign mode_sel = !paddr[2];
  assign prdata   = mode_sel ? {31'd0, prefix_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && mode_sel) begin
      prefix_mode <= pwdata[0];
    end
  end

  lprr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .byte_in  (byte_in),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  lprr_back #(
    .RING_BYTES (RING_BYTES),
    .MAX_RECORD (MAX_RECORD)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .prefix_mode   (prefix_mode),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .data_word     (data_word),
    .byte_count    (byte_count),
    .record_length (record_length),
    .status        (status),
    .last          (last)
  );

endmodule

`default_nettype wire

// ----- rtl/lprr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lprr_checker #(
  parameter int MAX_RECORD = 140
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] data_word,
  input wire logic [2:0]  byte_count,
  input wire logic [7:0]  record_length,
  input wire logic [2:0]  status,
  input wire logic        last
);
  import lprr_pkg::*;

  `LPRR_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(data_word) && $stable(status) && $stable(last), "Stalled result item changed.")
  `LPRR_ASSERT_IMP(a_single_last, clk, rst, out_valid && status != ST_DELIVERED, last, "A single result item lacks its last mark.")
  `LPRR_ASSERT_IMP(a_empty_fields, clk, rst, out_valid && status != ST_DELIVERED, data_word == 32'd0 && byte_count == 3'd0 && record_length == 8'd0, "A non-record item carries data.")
  `LPRR_ASSERT_IMP(a_rec_bounds, clk, rst, out_valid && status == ST_DELIVERED, byte_count <= 3'd4 && record_length <= 8'(MAX_RECORD) && (byte_count != 3'd0 || last), "Record item out of bounds.")

endmodule

bind length_prefixed_record_ring_core lprr_checker #(
  .MAX_RECORD (MAX_RECORD)
) u_lprr_checker (.*);

`default_nettype wire
